// File: hdl/dpp_pkg.sv
// Shared types and constants for the dual-track pedal plausibility check.
// Holds the transfer payload structs, fault codes and register indexes.
// No dependencies.
package dpp_pkg;

  localparam int SCALE_FULL_DEF = 1000;
  localparam int SAMPLE_W       = 16;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 16;
  localparam int LIMIT_W        = 10;
  localparam int POS_W          = 10;

  typedef enum logic [2:0] {
    FLT_OK       = 3'd0,
    FLT_HIGH_ONE = 3'd1,
    FLT_LOW_ONE  = 3'd2,
    FLT_HIGH_TWO = 3'd3,
    FLT_LOW_TWO  = 3'd4,
    FLT_MISMATCH = 3'd5,
    FLT_CAL      = 3'd6
  } fault_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_LOW_ONE   = 3'd0,
    CFG_HIGH_ONE  = 3'd1,
    CFG_LOW_TWO   = 3'd2,
    CFG_HIGH_TWO  = 3'd3,
    CFG_TWO_POTS  = 3'd4,
    CFG_INVERTED  = 3'd5,
    CFG_RANGE_TOL = 3'd6,
    CFG_MIS_LIMIT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_one;
    logic [SAMPLE_W-1:0] sample_two;
  } in_item_t;

  typedef struct packed {
    logic              signal_ok;
    logic [2:0]        fault_code;
    logic [POS_W-1:0]  pedal_position;
  } out_item_t;

endpackage

// File: hdl/dual_pot_pedal_check.sv
// Top level of the dual-track pedal plausibility check: config registers,
// scaling multiply, range and mismatch checks. Depends on dpp_pkg, dpp_div.
//
//   port group  direction  handshake         payload
//   in_*        in         valid / ready     in_item_t  (sample_one, sample_two)
//   out_*       out        valid / ready     out_item_t (signal_ok, fault_code,
//                                                        pedal_position)
//   cfg_*       in         write enable      cfg_addr, cfg_wdata
//
// One pair is taken per cycle while no result is held; each pair passes the scaling
// stage, the one-bit-per-stage divider and stages T1 to T3.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. A stalled result freezes the whole pipeline, which keeps
// every item in place; in_ready stays high while out is empty or taken.
module dual_pot_pedal_check #(
  parameter int SCALE_FULL = dpp_pkg::SCALE_FULL_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dpp_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dpp_pkg::out_item_t            out_data,
  input  logic                          cfg_wr_en,
  input  logic [dpp_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [dpp_pkg::CFG_DW-1:0]    cfg_wdata
);

  import dpp_pkg::*;

  localparam int SW  = $clog2(SCALE_FULL + 1);
  localparam int NW  = SAMPLE_W + 1 + SW + 1;
  localparam int DW  = SAMPLE_W + 1;
  localparam int QW  = $clog2(SCALE_FULL + 1025);
  localparam int CTW = QW + 2;
  localparam int MW  = (SW + 2 > 12) ? SW + 2 : 12;
  localparam int PW  = (SW > POS_W) ? SW : POS_W;

  localparam logic signed [NW-1:0]  SCALE_N = NW'(SCALE_FULL);
  localparam logic signed [CTW-1:0] SCALE_C = CTW'(SCALE_FULL);
  localparam logic signed [MW-1:0]  SCALE_M = MW'(SCALE_FULL);
  localparam logic [SW-1:0]         SCALE_S = SW'(SCALE_FULL);

  // configuration registers
  logic [SAMPLE_W-1:0] low1_r, high1_r, low2_r, high2_r;
  logic                two_r, inv_r;
  logic [LIMIT_W-1:0]  tol_r, mis_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low1_r    <= '0;
      high1_r   <= SAMPLE_W'(4095);
      low2_r    <= '0;
      high2_r   <= SAMPLE_W'(4095);
      two_r     <= 1'b1;
      inv_r     <= 1'b0;
      tol_r     <= LIMIT_W'(150);
      mis_lim_r <= LIMIT_W'(150);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_LOW_ONE:   low1_r    <= cfg_wdata[SAMPLE_W-1:0];
        CFG_HIGH_ONE:  high1_r   <= cfg_wdata[SAMPLE_W-1:0];
        CFG_LOW_TWO:   low2_r    <= cfg_wdata[SAMPLE_W-1:0];
        CFG_HIGH_TWO:  high2_r   <= cfg_wdata[SAMPLE_W-1:0];
        CFG_TWO_POTS:  two_r     <= cfg_wdata[0];
        CFG_INVERTED:  inv_r     <= cfg_wdata[0];
        CFG_RANGE_TOL: tol_r     <= cfg_wdata[LIMIT_W-1:0];
        CFG_MIS_LIMIT: mis_lim_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  out_item_t out_data_r;

  // whole pipeline advances unless a finished result is being held
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage 0: offset and scaling multiply
  logic                 v0_r;
  logic signed [NW-1:0] num_r [2];
  logic signed [DW-1:0] den_r [2];
  logic signed [DW-1:0] diff_nxt [2];
  logic signed [DW-1:0] den_nxt  [2];

  always_comb begin
    diff_nxt[0] = $signed({1'b0, in_data.sample_one}) - $signed({1'b0, low1_r});
    diff_nxt[1] = $signed({1'b0, in_data.sample_two}) - $signed({1'b0, low2_r});
    den_nxt[0]  = $signed({1'b0, high1_r}) - $signed({1'b0, low1_r});
    den_nxt[1]  = $signed({1'b0, high2_r}) - $signed({1'b0, low2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        num_r[l] <= NW'(diff_nxt[l]) * SCALE_N;
        den_r[l] <= den_nxt[l];
      end
    end
  end

  logic              dv;
  logic signed [QW:0] quo [2];

  dpp_div #(
    .NW (NW),
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v0_r),
    .num       (num_r),
    .den       (den_r),
    .out_valid (dv),
    .quo       (quo)
  );

  // stage T1: range check and clamp of each track
  logic signed [CTW-1:0] cx [2];
  logic signed [CTW-1:0] tol_c;
  logic                  v1_r;
  logic                  hi_r [2];
  logic                  lo_r [2];
  logic [SW-1:0]         cl_r [2];

  always_comb begin
    tol_c = $signed(CTW'(tol_r));
    cx[0] = (!two_r && inv_r) ? SCALE_C - CTW'(quo[0]) : CTW'(quo[0]);
    cx[1] = CTW'(quo[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= dv;
    end
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        hi_r[l] <= cx[l] > SCALE_C + tol_c;
        lo_r[l] <= cx[l] < -tol_c;
        if (cx[l] > SCALE_C) begin
          cl_r[l] <= SCALE_S;
        end else if (cx[l] < 0) begin
          cl_r[l] <= '0;
        end else begin
          cl_r[l] <= cx[l][SW-1:0];
        end
      end
    end
  end

  // stage T2: track disagreement and averaged position
  logic signed [MW-1:0] c1m, c2m, m_nxt;
  logic [SW-1:0]        c2p;
  logic [SW:0]          psum;
  logic                 v2_r;
  logic signed [MW-1:0] m_r;
  logic [SW-1:0]        pos_r;
  logic                 hi2_r [2];
  logic                 lo2_r [2];

  always_comb begin
    c1m   = $signed(MW'(cl_r[0]));
    c2m   = $signed(MW'(cl_r[1]));
    m_nxt = inv_r ? SCALE_M - c1m - c2m : c1m - c2m;
    c2p   = inv_r ? SCALE_S - cl_r[1] : cl_r[1];
    psum  = {1'b0, cl_r[0]} + {1'b0, c2p};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      m_r   <= m_nxt;
      pos_r <= two_r ? psum[SW:1] : cl_r[0];
      for (int l = 0; l < 2; l++) begin
        hi2_r[l] <= hi_r[l];
        lo2_r[l] <= lo_r[l];
      end
    end
  end

  // stage T3: fault priority and result register
  logic signed [MW-1:0] lim;
  logic                 mis;
  fault_t               code;
  logic [PW-1:0]        pos_w;

  always_comb begin
    lim   = $signed(MW'(mis_lim_r));
    mis   = (m_r > lim) || (m_r < -lim);
    pos_w = PW'(pos_r);
    if (low1_r == high1_r) begin
      code = FLT_CAL;
    end else if (two_r && low2_r == high2_r) begin
      code = FLT_CAL;
    end else if (hi2_r[0]) begin
      code = FLT_HIGH_ONE;
    end else if (lo2_r[0]) begin
      code = FLT_LOW_ONE;
    end else if (two_r && hi2_r[1]) begin
      code = FLT_HIGH_TWO;
    end else if (two_r && lo2_r[1]) begin
      code = FLT_LOW_TWO;
    end else if (two_r && mis) begin
      code = FLT_MISMATCH;
    end else begin
      code = FLT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r;
    end
    if (adv) begin
      out_data_r.signal_ok      <= (code == FLT_OK);
      out_data_r.fault_code     <= code;
      out_data_r.pedal_position <= (code == FLT_OK) ? pos_w[POS_W-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_ok_has_no_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.signal_ok |-> out_data_r.fault_code == FLT_OK)
    else $error("ok result carries a fault code");

  a_fault_zero_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.signal_ok |-> out_data_r.pedal_position == '0)
    else $error("faulted result carries a position");

  a_pos_in_scale : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.signal_ok |->
      (SCALE_FULL > 1023) || (PW'(out_data_r.pedal_position) <= PW'(SCALE_FULL)))
    else $error("position beyond full scale");

  a_clamp_in_scale : assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> cl_r[0] <= SCALE_S && cl_r[1] <= SCALE_S)
    else $error("clamped track beyond full scale");
`endif

endmodule

// File: hdl/dpp_div.sv
// Two-lane pipelined signed divider, one quotient bit per stage, truncating
// toward zero. Quotients too large for QW bits saturate to the largest
// magnitude. No dependencies.
module dpp_div #(
  parameter int NW = 28,
  parameter int DW = 17,
  parameter int QW = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num [2],
  input  logic signed [DW-1:0] den [2],
  output logic                 out_valid,
  output logic signed [QW:0]   quo [2]
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;
  localparam logic signed [QW:0] QMAX = {1'b0, {QW{1'b1}}};

  // magnitude stage
  logic          va_r;
  logic [NW-1:0] nmag_r [2];
  logic [DW-1:0] dmag_r [2];
  logic          nega_r [2];

  // bit stages: index 0 is the saturation check, index QW the last bit
  logic          vi_r   [0:QW];
  logic [CW-1:0] remi_r [0:QW][2];
  logic [DW-1:0] deni_r [0:QW][2];
  logic [QW-1:0] qi_r   [0:QW][2];
  logic          negi_r [0:QW][2];
  logic          sati_r [0:QW][2];

  logic          vo_r;
  logic signed [QW:0] quo_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        nmag_r[l] <= num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
        dmag_r[l] <= den[l][DW-1] ? DW'(-den[l]) : DW'(den[l]);
        nega_r[l] <= num[l][NW-1] ^ den[l][DW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r[0] <= 1'b0;
    end else if (en) begin
      vi_r[0] <= va_r;
    end
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        remi_r[0][l] <= CW'(nmag_r[l]);
        deni_r[0][l] <= dmag_r[l];
        qi_r[0][l]   <= '0;
        negi_r[0][l] <= nega_r[l];
        sati_r[0][l] <= CW'(nmag_r[l]) >= (CW'(dmag_r[l]) << QW);
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int B = QW - 1 - j;
    logic [CW-1:0] trial [2];
    logic          ge    [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = CW'(deni_r[j][l]) << B;
        ge[l]    = remi_r[j][l] >= trial[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vi_r[j+1] <= 1'b0;
      end else if (en) begin
        vi_r[j+1] <= vi_r[j];
      end
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          remi_r[j+1][l]    <= ge[l] ? remi_r[j][l] - trial[l] : remi_r[j][l];
          qi_r[j+1][l]      <= qi_r[j][l] | (QW'(ge[l]) << B);
          deni_r[j+1][l]    <= deni_r[j][l];
          negi_r[j+1][l]    <= negi_r[j][l];
          sati_r[j+1][l]    <= sati_r[j][l];
        end
      end
    end
  end

  // apply saturation and sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vi_r[QW];
    end
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        if (sati_r[QW][l]) begin
          quo_r[l] <= negi_r[QW][l] ? -QMAX : QMAX;
        end else begin
          quo_r[l] <= negi_r[QW][l] ? -$signed({1'b0, qi_r[QW][l]})
                                    : $signed({1'b0, qi_r[QW][l]});
        end
      end
    end
  end

  assign out_valid = vo_r;
  assign quo[0]    = quo_r[0];
  assign quo[1]    = quo_r[1];

`ifndef NO_ASSERTIONS
  a_rem_below_den : assert property (@(posedge clk) disable iff (!rst_n)
    vi_r[QW] && !sati_r[QW][0] && !sati_r[QW][1] |->
      remi_r[QW][0] < CW'(deni_r[QW][0]) && remi_r[QW][1] < CW'(deni_r[QW][1]))
    else $error("divider remainder not below divisor");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vo_r))
    else $error("divider output valid moved while held");

  a_sat_quotient : assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && $past(sati_r[QW][0]) && $past(en) |->
      (quo_r[0] == QMAX) || (quo_r[0] == -QMAX))
    else $error("saturated quotient not at full magnitude");
`endif

endmodule

// File: test/dual_pot_pedal_check_test.sv
`timescale 1ns / 1ps
// Self-checking bench for dual_pot_pedal_check: directed table, then random config phases.
// Depends on dpp_pkg and the dual_pot_pedal_check RTL only.
module dual_pot_pedal_check_test;
  import dpp_pkg::*;

  localparam int SCALE     = SCALE_FULL_DEF;
  localparam int PIPE_LAT  = $clog2(SCALE_FULL_DEF + 1025) + 7;
  localparam int HOLD_OFF  = 250;
  localparam int PHASES    = 10;
  localparam int PER_PHASE = 90;

  typedef struct packed {
    logic [15:0] low_one;
    logic [15:0] high_one;
    logic [15:0] low_two;
    logic [15:0] high_two;
    logic        two_pots;
    logic        inverted;
    logic [9:0]  tolerance;
    logic [9:0]  mis_limit;
  } settings_t;

  typedef struct {
    settings_t cfg;
    in_item_t  pair;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  typedef enum {SET_DEFAULT, SET_WIDE, SET_REVERSED, SET_CAL_TWO, SET_RANDOM} set_kind_t;

  localparam settings_t RESET_SET = '{16'd0, 16'd4095, 16'd0, 16'd4095, 1'b1, 1'b0,
                                      10'd150, 10'd150};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  settings_t active = RESET_SET;
  out_item_t expected_q[$];
  stim_row_t directed_rows[$];
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  bit stall_request = 1'b0;
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int per_code[8];

  dual_pot_pedal_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Per-mille position of one track, signed, truncated toward zero.
  function automatic longint to_permille(int x, int lo, int hi);
    longint num;
    longint den;
    num = (longint'(x) - longint'(lo)) * SCALE;
    den = longint'(hi) - longint'(lo);
    return num / den;
  endfunction

  // Range-check one track; clamp it into 0..SCALE when within tolerance.
  function automatic fault_t clamp_track(inout longint v, input fault_t hi_code,
                                         input fault_t lo_code);
    longint tol;
    tol = longint'(active.tolerance);
    if (v > SCALE + tol) return hi_code;
    if (v > SCALE) v = SCALE;
    if (v < -tol) return lo_code;
    if (v < 0) v = 0;
    return FLT_OK;
  endfunction

  function automatic out_item_t judge_pedal(in_item_t s);
    out_item_t r;
    longint c1;
    longint c2;
    longint gap;
    fault_t code;
    c1 = 0;
    c2 = 0;
    code = FLT_OK;
    if (active.low_one == active.high_one ||
        (active.two_pots && active.low_two == active.high_two)) begin
      code = FLT_CAL;
    end else begin
      c1 = to_permille(s.sample_one, active.low_one, active.high_one);
      if (!active.two_pots && active.inverted) c1 = SCALE - c1;
      code = clamp_track(c1, FLT_HIGH_ONE, FLT_LOW_ONE);
      if (code == FLT_OK && active.two_pots) begin
        c2 = to_permille(s.sample_two, active.low_two, active.high_two);
        code = clamp_track(c2, FLT_HIGH_TWO, FLT_LOW_TWO);
        if (code == FLT_OK) begin
          gap = active.inverted ? SCALE - c1 - c2 : c1 - c2;
          if (gap < 0) gap = -gap;
          if (gap > longint'(active.mis_limit)) code = FLT_MISMATCH;
          if (active.inverted) c2 = SCALE - c2;
          c1 = (c1 + c2) / 2;
        end
      end
    end
    r.signal_ok = (code == FLT_OK);
    r.fault_code = code;
    r.pedal_position = (code == FLT_OK) ? c1[POS_W-1:0] : '0;
    return r;
  endfunction

  // Raw reading that lands near a wanted per-mille position.
  function automatic logic [15:0] raw_for(int p, int lo, int hi);
    longint x;
    x = longint'(lo) + (longint'(p) * (longint'(hi) - longint'(lo))) / SCALE
        + int'($urandom_range(0, 2)) - 1;
    if (x < 0) x = 0;
    if (x > 65535) x = 65535;
    return x[15:0];
  endfunction

  function automatic settings_t roll_settings(set_kind_t kind);
    settings_t s;
    int span;
    s.low_one = 16'($urandom);
    s.high_one = 16'($urandom);
    s.low_two = 16'($urandom);
    s.high_two = 16'($urandom);
    s.two_pots = 1'($urandom_range(0, 1));
    s.inverted = 1'($urandom_range(0, 1));
    s.tolerance = 10'($urandom_range(0, SCALE));
    s.mis_limit = 10'($urandom_range(0, SCALE));
    // narrow spans stress the truncation
    if ($urandom_range(0, 3) == 0) begin
      span = $urandom_range(1, 20);
      s.high_one = 16'((s.low_one > 65535 - span) ? s.low_one - span : s.low_one + span);
      s.high_two = 16'((s.low_two > 65535 - span) ? s.low_two - span : s.low_two + span);
    end
    if (s.low_one == s.high_one) s.high_one = ~s.low_one;
    if (s.low_two == s.high_two) s.high_two = ~s.low_two;
    case (kind)
      SET_DEFAULT: s = RESET_SET;
      SET_WIDE: begin
        s = '{16'd0, 16'hffff, 16'd0, 16'hffff, 1'b1, s.inverted, 10'd1000, 10'd1000};
      end
      SET_REVERSED: begin
        s = '{16'hffff, 16'd0, 16'hffff, 16'd0, 1'b1, s.inverted, 10'd0, 10'd0};
      end
      SET_CAL_TWO: s.high_two = s.low_two;
      default: ;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(negedge clk);
  endtask

  task automatic apply_settings(settings_t s);
    put_reg(CFG_LOW_ONE, s.low_one);
    put_reg(CFG_HIGH_ONE, s.high_one);
    put_reg(CFG_LOW_TWO, s.low_two);
    put_reg(CFG_HIGH_TWO, s.high_two);
    put_reg(CFG_TWO_POTS, {15'd0, s.two_pots});
    put_reg(CFG_INVERTED, {15'd0, s.inverted});
    put_reg(CFG_RANGE_TOL, {6'd0, s.tolerance});
    put_reg(CFG_MIS_LIMIT, {6'd0, s.mis_limit});
    cfg_wr_en <= 1'b0;
    active = s;
    settings_used++;
  endtask

  // Drop valid and let the pipeline empty before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 2) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_sample(in_item_t s, bit typed, out_item_t want);
    while (!sender_calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(typed ? want : judge_pedal(s));
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic add_row(settings_t c, int a, int b, bit typed, fault_t code = FLT_OK,
                         int pos = 0);
    stim_row_t r;
    r.cfg = c;
    r.pair.sample_one = 16'(a);
    r.pair.sample_two = 16'(b);
    r.typed = typed;
    r.want.signal_ok = (code == FLT_OK);
    r.want.fault_code = code;
    r.want.pedal_position = POS_W'(pos);
    directed_rows.push_back(r);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        stall_request = 1'b0;
      end else begin
        out_ready <= receiver_calm || $urandom_range(0, 99) >= 15;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    out_item_t due;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      per_code[out_data.fault_code]++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (code %0d)",
                                  out_data.fault_code));
      end else begin
        due = expected_q.pop_front();
        if (out_data.signal_ok !== due.signal_ok)
          report_mismatch($sformatf("signal_ok %b, want %b", out_data.signal_ok,
                                    due.signal_ok));
        if (out_data.fault_code !== due.fault_code)
          report_mismatch($sformatf("fault_code %0d, want %0d", out_data.fault_code,
                                    due.fault_code));
        if (out_data.pedal_position !== due.pedal_position)
          report_mismatch($sformatf("pedal_position %0d, want %0d",
                                    out_data.pedal_position, due.pedal_position));
      end
    end
  end

  initial begin
    settings_t inv_set;
    settings_t cal_one;
    settings_t cal_two;
    settings_t one_pot;
    settings_t rev_set;
    settings_t single_inv;
    settings_t wide_set;
    set_kind_t plan[PHASES];
    in_item_t pair;
    int mix;
    int p1;
    int p2;
    int spin;

    plan = '{SET_DEFAULT, SET_WIDE, SET_RANDOM, SET_REVERSED, SET_RANDOM, SET_CAL_TWO,
             SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM};
    inv_set = RESET_SET;
    inv_set.inverted = 1'b1;
    cal_one = RESET_SET;
    cal_one.low_one = 16'd100;
    cal_one.high_one = 16'd100;
    cal_two = RESET_SET;
    cal_two.low_two = 16'd7;
    cal_two.high_two = 16'd7;
    one_pot = cal_two;
    one_pot.two_pots = 1'b0;
    rev_set = '{16'd4000, 16'd1000, 16'd4000, 16'd1000, 1'b1, 1'b0, 10'd150, 10'd150};
    single_inv = '{16'd1000, 16'd3000, 16'd0, 16'd0, 1'b0, 1'b1, 10'd0, 10'd0};
    wide_set = '{16'd0, 16'hffff, 16'd0, 16'hffff, 1'b1, 1'b0, 10'd1000, 10'd1000};

    add_row(RESET_SET, 0, 0, 1, FLT_OK, 0);
    add_row(RESET_SET, 4095, 4095, 1, FLT_OK, 1000);
    add_row(RESET_SET, 65535, 0, 1, FLT_HIGH_ONE);
    add_row(RESET_SET, 0, 65535, 1, FLT_HIGH_TWO);
    add_row(RESET_SET, 0, 4095, 1, FLT_MISMATCH);
    add_row(RESET_SET, 2048, 2000, 0);
    add_row(RESET_SET, 4710, 4710, 0);   // just inside tolerance: clamps
    add_row(RESET_SET, 4714, 4714, 0);   // just past tolerance
    add_row(RESET_SET, 2048, 2662, 0);   // disagreement right at the limit
    add_row(inv_set, 0, 4095, 0);
    add_row(inv_set, 4095, 0, 0);
    add_row(inv_set, 0, 0, 1, FLT_MISMATCH);
    add_row(cal_one, 1234, 5678, 1, FLT_CAL);
    add_row(cal_one, 65535, 65535, 1, FLT_CAL);
    add_row(cal_two, 0, 0, 1, FLT_CAL);
    add_row(one_pot, 4095, 0, 0);        // track two uncalibrated but unused
    add_row(rev_set, 4000, 4000, 1, FLT_OK, 0);
    add_row(rev_set, 1000, 1000, 1, FLT_OK, 1000);
    add_row(rev_set, 65535, 0, 1, FLT_LOW_ONE);
    add_row(rev_set, 4000, 65535, 1, FLT_LOW_TWO);
    add_row(rev_set, 4000, 0, 1, FLT_HIGH_TWO);
    add_row(single_inv, 1000, 0, 1, FLT_OK, 1000);
    add_row(single_inv, 999, 65535, 0);  // negative half truncates to zero
    add_row(single_inv, 998, 0, 0);
    add_row(single_inv, 3002, 0, 0);
    add_row(wide_set, 65535, 0, 0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != active) begin
        settle();
        apply_settings(directed_rows[i].cfg);
      end
      push_sample(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      apply_settings(roll_settings(plan[ph]));
      sender_calm = (ph == 4);
      receiver_calm = (ph == 4);
      // hold the receiver off while items keep coming, to back the pipeline up
      if (ph == 2) stall_request = 1'b1;
      repeat (PER_PHASE) begin
        mix = $urandom_range(0, 99);
        p1 = int'($urandom_range(0, 1040 + 2 * active.tolerance)) - active.tolerance - 20;
        p2 = (active.inverted && active.two_pots) ? SCALE - p1 : p1;
        p2 += int'($urandom_range(0, 40 + 2 * active.mis_limit)) - active.mis_limit - 20;
        if (mix < 80) begin
          pair.sample_one = raw_for(p1, active.low_one, active.high_one);
          pair.sample_two = raw_for(p2, active.low_two, active.high_two);
        end else if (mix < 90) begin
          pair.sample_one = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
          pair.sample_two = 16'($urandom);
        end else begin
          pair = $urandom;
        end
        push_sample(pair, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    spin = 0;
    while (expected_q.size() != 0 && spin < 20000) begin
      @(negedge clk);
      spin++;
    end
    repeat (PIPE_LAT + 8) @(negedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

    $display("Sent %0d sample pairs under %0d register settings; checked %0d results.",
             pairs_sent, settings_used, results_seen);
    $display("Codes seen: ok %0d, high1 %0d, low1 %0d, high2 %0d, low2 %0d, mism %0d, cal %0d",
             per_code[FLT_OK], per_code[FLT_HIGH_ONE], per_code[FLT_LOW_ONE],
             per_code[FLT_HIGH_TWO], per_code[FLT_LOW_TWO], per_code[FLT_MISMATCH],
             per_code[FLT_CAL]);
    if (errors == 0) begin
      $display("** dual_pot_pedal_check: PASSED **");
    end else begin
      $display("** dual_pot_pedal_check: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", expected_q.size());
    $display("** dual_pot_pedal_check: FAILED **");
    $finish;
  end

endmodule
